// ===== rtl/iss_pkg.sv =====
// Types and constants shared by the indexed sequence store and its cells.
package iss_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 5;
  // Wide enough for any position or length up to the largest supported capacity.
  localparam int unsigned CNT_W  = 9;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    SEL_INDEX = 2'd0,
    SEL_FRONT = 2'd1,
    SEL_BACK  = 2'd2
  } end_select_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [1:0]               end_select;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value_in;
  } iss_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [1:0]               status;
    logic [POS_W-1:0]         count_out;
  } iss_res_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] pos;
  } iss_bcast_t;

endpackage

// ===== rtl/iss_cell.sv =====
// One storage cell of the sequence chain: holds one entry and shifts with its neighbors.
module iss_cell
  import iss_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic                     clk_i,
  input  iss_bcast_t               ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic signed [DATA_W-1:0] rd_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(Idx);

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     match;

  assign match = (ctrl_i.pos == IdxC);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (match) begin
          data_d = value_i;
        end else if (IdxC > ctrl_i.pos) begin
          data_d = left_i;
        end
      end
      CELL_REMOVE: begin
        // Cells at or past the removed slot pull from their upper neighbor.
        if (IdxC >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = match ? data_q : '0;

endmodule

// ===== rtl/indexed_sequence_store_unit.sv =====
// Indexed sequence store: a chain of entry cells with a decode and result stage on top.
// The result word is registered and appears on res_o with res_valid_o in the cycle after start.
// Throughput: one request per cycle; busy stays low, since all cells shift together on each accepted request.
// Reset clears the length and the result strobe; the entry cells are not reset,
// and only entries below the current length are ever read.
module indexed_sequence_store_unit
  import iss_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  iss_req_t req_i,
  output logic     res_valid_o,
  output iss_res_t res_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  logic [CW-1:0]            count_q, count_d;
  logic                     res_valid_q;
  iss_res_t                 res_q, res_d;
  iss_bcast_t               bcast;
  logic                     accept;
  logic [CNT_W-1:0]         cnt_w, pos_w;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
  logic signed [DATA_W-1:0] rd_value;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign cnt_w  = CNT_W'(count_q);

  always_comb begin
    rd_value = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_value = rd_value | cell_rd[k];
    end
  end

  always_comb begin
    case (req_i.end_select)
      SEL_FRONT: pos_w = '0;
      SEL_BACK:  pos_w = (req_i.req_type == REQ_INSERT) ? cnt_w : cnt_w - CNT_W'(1);
      default:   pos_w = CNT_W'(req_i.position);
    endcase
  end

  always_comb begin
    bcast.op        = CELL_HOLD;
    bcast.pos       = pos_w;
    count_d         = count_q;
    res_d.value_out = '0;
    res_d.status    = ST_RANGE;
    if (req_i.end_select == SEL_INDEX || req_i.end_select == SEL_FRONT ||
        req_i.end_select == SEL_BACK) begin
      case (req_i.req_type)
        REQ_INSERT: begin
          if (cnt_w == CapC) begin
            res_d.status = ST_FULL;
          end else if (pos_w <= cnt_w) begin
            res_d.status = ST_OK;
            bcast.op     = CELL_INSERT;
            count_d      = count_q + CW'(1);
          end
        end
        REQ_REMOVE, REQ_READ: begin
          if (cnt_w == '0) begin
            res_d.status = ST_EMPTY;
          end else if (pos_w < cnt_w) begin
            res_d.status    = ST_OK;
            res_d.value_out = rd_value;
            if (req_i.req_type == REQ_REMOVE) begin
              bcast.op = CELL_REMOVE;
              count_d  = count_q - CW'(1);
            end
          end
        end
        default: res_d.status = ST_RANGE;
      endcase
    end
    if (!accept) begin
      bcast.op = CELL_HOLD;
      count_d  = count_q;
    end
    res_d.count_out = POS_W'(count_d);
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = req_i.value_in;
    end else begin : g_mid_l
      assign left = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = cell_data[k];
    end else begin : g_mid_r
      assign right = cell_data[k+1];
    end
    iss_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (bcast),
      .value_i (req_i.value_in),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[k]),
      .rd_o    (cell_rd[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
